// ===== hw/rtl/gcd_pkg.sv =====
package gcd_pkg;

  // Angle and field formats
  localparam int ANGLE_FRAC_BITS = 20;
  localparam int CORDIC_STAGES   = 24;
  localparam int SQRT_STAGES     = 31;
  localparam int LAT_W           = 30;
  localparam int LON_W           = 29;
  localparam int RAD_W           = 24;
  localparam int OUT_W           = 26;
  localparam int MAG_W           = 27;
  localparam int RND_SH          = ANGLE_FRAC_BITS + 2;

  // Angles in units of 2^-ANGLE_FRAC_BITS degree
  localparam logic signed [31:0] FULL_ANG    = 32'(longint'(360) << ANGLE_FRAC_BITS);
  localparam logic signed [31:0] HALF_ANG    = 32'(longint'(180) << ANGLE_FRAC_BITS);
  localparam logic signed [31:0] QUARTER_ANG = 32'(longint'(90) << ANGLE_FRAC_BITS);

  // Q30 constants (DEG2RAD_Q32 is Q32), reset radius and output limit
  localparam logic signed [31:0] INV_GAIN_Q  = 32'sd652032874;
  localparam logic [32:0]        PI_Q        = 33'd3373259426;
  localparam logic [MAG_W-1:0]   DEG2RAD_Q32 = 27'd74961321;
  localparam logic [RAD_W-1:0]   RADIUS_RESET = 24'd6370997;
  localparam logic [OUT_W-1:0]   OUT_MAX      = 26'd52707178;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic signed [31:0] z_a;
    logic signed [31:0] z_b;
    logic signed [31:0] z_d;
    logic [2:0]         neg;
  } gcd_angles_t;

  function automatic logic signed [31:0] atan_q30(input int i);
    logic signed [31:0] v;
    case (i)
      0:       v = 32'sd843314856;
      1:       v = 32'sd497837829;
      2:       v = 32'sd263043836;
      3:       v = 32'sd133525158;
      4:       v = 32'sd67021686;
      5:       v = 32'sd33543515;
      6:       v = 32'sd16775850;
      7:       v = 32'sd8388437;
      8:       v = 32'sd4194282;
      9:       v = 32'sd2097149;
      10:      v = 32'sd1048575;
      11:      v = 32'sd524287;
      12:      v = 32'sd262143;
      13:      v = 32'sd131071;
      14:      v = 32'sd65535;
      15:      v = 32'sd32767;
      16:      v = 32'sd16383;
      17:      v = 32'sd8191;
      18:      v = 32'sd4095;
      19:      v = 32'sd2047;
      20:      v = 32'sd1023;
      21:      v = 32'sd511;
      22:      v = 32'sd255;
      23:      v = 32'sd127;
      24:      v = 32'sd63;
      25:      v = 32'sd31;
      26:      v = 32'sd15;
      27:      v = 32'sd7;
      28:      v = 32'sd3;
      29:      v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/great_circle_distance_core.sv =====
// Great circle distance, spherical law of cosines.
// Input channel: in_valid_i / in_stall_o carry one beat per point pair:
//   two latitudes and two longitudes, signed, units of 2^-20 degree.
// Output channel: out_valid_o / out_stall_i carry one beat per pair with
//   arc_distance_m_o, the distance in meters, saturated at 52707178.
// Config channel: cfg_valid_i / cfg_ready_o write the 24-bit sphere radius
//   in meters; ready is always high. Write it only while the core is idle.
// Throughput: one pair per cycle, sustained, when the output is not stalled.
// Path: each beat passes 4 front stages, the queue, then 89 back stages;
//   the depth is set by the two 24-stage CORDIC pipelines and the
//   31-stage square root between them.
// Structure: a 4-stage front (latitude fold, angle reduction, degrees to
//   radians, rounding) feeds a 4-entry queue; the back pipeline pops it.
// Stall: out_stall_i on a valid output freezes the back pipeline; the front keeps accepting
//   until the queue fills, then raises in_stall_o.
// Reset: all valid bits and queue pointers clear, radius returns to 6370997.
module great_circle_distance_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gcd_pkg::RAD_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [gcd_pkg::LAT_W-1:0] first_latitude_i,
  input  logic signed [gcd_pkg::LON_W-1:0] first_longitude_i,
  input  logic signed [gcd_pkg::LAT_W-1:0] second_latitude_i,
  input  logic signed [gcd_pkg::LON_W-1:0] second_longitude_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [gcd_pkg::OUT_W-1:0]        arc_distance_m_o
);

  logic [gcd_pkg::RAD_W-1:0] radius_q;

  logic                 f_valid, f_ready;
  gcd_pkg::gcd_angles_t f_data;
  logic                 q_valid, q_pop;
  gcd_pkg::gcd_angles_t q_data;

  assign cfg_ready_o = 1'b1;

  // radius register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) radius_q <= gcd_pkg::RADIUS_RESET;
    else if (cfg_valid_i && cfg_ready_o) radius_q <= cfg_data_i;
  end

  gcd_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .first_latitude_i   (first_latitude_i),
    .first_longitude_i  (first_longitude_i),
    .second_latitude_i  (second_latitude_i),
    .second_longitude_i (second_longitude_i),
    .out_valid_o        (f_valid),
    .out_ready_i        (f_ready),
    .out_data_o         (f_data)
  );

  gcd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_data)
  );

  gcd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (q_valid),
    .in_pop_o         (q_pop),
    .in_data_i        (q_data),
    .radius_i         (radius_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .arc_distance_m_o (arc_distance_m_o)
  );

endmodule

// ===== hw/rtl/gcd_front.sv =====
module gcd_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [gcd_pkg::LAT_W-1:0]   first_latitude_i,
  input  logic signed [gcd_pkg::LON_W-1:0]   first_longitude_i,
  input  logic signed [gcd_pkg::LAT_W-1:0]   second_latitude_i,
  input  logic signed [gcd_pkg::LON_W-1:0]   second_longitude_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output gcd_pkg::gcd_angles_t               out_data_o
);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [31:0] ang_q [3];
  logic [gcd_pkg::MAG_W-1:0] mag_q [3];
  logic [2:0] sgn2_q, neg2_q, sgn3_q, neg3_q;
  logic [2*gcd_pkg::MAG_W-1:0] prod_q [3];
  logic signed [31:0] z_q [3];
  logic [2:0] neg4_q;

  logic signed [31:0] lat_a, lat_b;

  assign en         = !(v4_q && !out_ready_i);
  assign in_stall_o = !en;

  // latitude above 90 degrees folds down by 180
  always_comb begin
    lat_a = {{(32-gcd_pkg::LAT_W){first_latitude_i[gcd_pkg::LAT_W-1]}}, first_latitude_i};
    lat_b = {{(32-gcd_pkg::LAT_W){second_latitude_i[gcd_pkg::LAT_W-1]}}, second_latitude_i};
    if (lat_a > gcd_pkg::QUARTER_ANG) lat_a = lat_a - gcd_pkg::HALF_ANG;
    if (lat_b > gcd_pkg::QUARTER_ANG) lat_b = lat_b - gcd_pkg::HALF_ANG;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: adjusted latitudes and longitude difference
  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[0] <= lat_a;
      ang_q[1] <= lat_b;
      ang_q[2] <= {{(32-gcd_pkg::LON_W){first_longitude_i[gcd_pkg::LON_W-1]}},
                   first_longitude_i}
                - {{(32-gcd_pkg::LON_W){second_longitude_i[gcd_pkg::LON_W-1]}},
                   second_longitude_i};
    end
  end

  // stage 2: reduce into (-180,180], fold into [-90,90]
  always_ff @(posedge clk_i) begin
    logic signed [31:0] r;
    logic               n;
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        r = ang_q[l];
        n = 1'b0;
        if (r > gcd_pkg::HALF_ANG) r = r - gcd_pkg::FULL_ANG;
        else if (r <= -gcd_pkg::HALF_ANG) r = r + gcd_pkg::FULL_ANG;
        if (r > gcd_pkg::QUARTER_ANG) begin
          r = r - gcd_pkg::HALF_ANG;
          n = 1'b1;
        end else if (r < -gcd_pkg::QUARTER_ANG) begin
          r = r + gcd_pkg::HALF_ANG;
          n = 1'b1;
        end
        neg2_q[l] <= n;
        sgn2_q[l] <= r[31];
        mag_q[l]  <= r[31] ? gcd_pkg::MAG_W'(-r) : gcd_pkg::MAG_W'(r);
      end
    end
  end

  // stage 3: degrees to radians
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        prod_q[l] <= (2*gcd_pkg::MAG_W)'(mag_q[l]) * (2*gcd_pkg::MAG_W)'(gcd_pkg::DEG2RAD_Q32);
      end
      sgn3_q <= sgn2_q;
      neg3_q <= neg2_q;
    end
  end

  // stage 4: round half up, restore sign
  always_ff @(posedge clk_i) begin
    logic [2*gcd_pkg::MAG_W:0] s;
    logic [31:0] m;
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        s = {1'b0, prod_q[l]} + ((2*gcd_pkg::MAG_W+1)'(1) << (gcd_pkg::RND_SH - 1));
        m = 32'(s >> gcd_pkg::RND_SH);
        z_q[l] <= sgn3_q[l] ? -$signed(m) : $signed(m);
      end
      neg4_q <= neg3_q;
    end
  end

  assign out_valid_o     = v4_q;
  assign out_data_o.z_a  = z_q[0];
  assign out_data_o.z_b  = z_q[1];
  assign out_data_o.z_d  = z_q[2];
  assign out_data_o.neg  = neg4_q;

endmodule

// ===== hw/rtl/gcd_fifo.sv =====
module gcd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 push_ready_o,
  input  gcd_pkg::gcd_angles_t push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_i,
  output gcd_pkg::gcd_angles_t pop_data_o
);

  localparam logic [gcd_pkg::FIFO_AW:0] FULL_CNT = (gcd_pkg::FIFO_AW+1)'(gcd_pkg::FIFO_DEPTH);

  gcd_pkg::gcd_angles_t mem_q [gcd_pkg::FIFO_DEPTH];
  logic [gcd_pkg::FIFO_AW-1:0] wr_q, rd_q;
  logic [gcd_pkg::FIFO_AW:0]   count_q;
  logic do_push, do_pop;

  assign push_ready_o = count_q != FULL_CNT;
  assign pop_valid_o  = count_q != '0;
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (!do_push && do_pop) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT) else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> pop_valid_o) else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count missed a push");

endmodule

// ===== hw/rtl/gcd_back.sv =====
module gcd_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_pop_o,
  input  gcd_pkg::gcd_angles_t             in_data_i,
  input  logic [gcd_pkg::RAD_W-1:0]        radius_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [gcd_pkg::OUT_W-1:0]        arc_distance_m_o
);

  localparam int CS   = gcd_pkg::CORDIC_STAGES;
  localparam int SQ   = gcd_pkg::SQRT_STAGES;
  localparam int NSTG = 1 + CS + 4 + 2 + SQ + CS + 3;

  logic en;
  logic [NSTG-1:0] vld_q;

  assign en       = !(out_valid_o && out_stall_i);
  assign in_pop_o = en && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[NSTG-2:0], in_pop_o};
  end

  // sine/cosine rotation pipeline, three lanes
  logic signed [31:0] rx_q [0:CS][3];
  logic signed [31:0] ry_q [0:CS][3];
  logic signed [31:0] rz_q [0:CS][3];
  logic [2:0]         rn_q [0:CS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rx_q[0][l] <= gcd_pkg::INV_GAIN_Q;
        ry_q[0][l] <= '0;
      end
      rz_q[0][0] <= in_data_i.z_a;
      rz_q[0][1] <= in_data_i.z_b;
      rz_q[0][2] <= in_data_i.z_d;
      rn_q[0]    <= in_data_i.neg;
    end
  end

  for (genvar i = 1; i <= CS; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      logic signed [31:0] dx, dy;
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          dx = ry_q[i-1][l] >>> (i-1);
          dy = rx_q[i-1][l] >>> (i-1);
          if (!rz_q[i-1][l][31]) begin
            rx_q[i][l] <= rx_q[i-1][l] - dx;
            ry_q[i][l] <= ry_q[i-1][l] + dy;
            rz_q[i][l] <= rz_q[i-1][l] - gcd_pkg::atan_q30(i-1);
          end else begin
            rx_q[i][l] <= rx_q[i-1][l] + dx;
            ry_q[i][l] <= ry_q[i-1][l] - dy;
            rz_q[i][l] <= rz_q[i-1][l] + gcd_pkg::atan_q30(i-1);
          end
        end
        rn_q[i] <= rn_q[i-1];
      end
    end
  end

  // cos(dtheta) = sa*sb + (ca*cb)*cd
  logic signed [31:0] sa, sb, ca, cb, cd;
  logic signed [63:0] ss_q, cc_q, t_q;
  logic signed [31:0] cp_q, cp2_q, cs_q, c_q;
  logic signed [33:0] ss2_q, ss3_q;

  always_comb begin
    sa = rn_q[CS][0] ? -ry_q[CS][0] : ry_q[CS][0];
    ca = rn_q[CS][0] ? -rx_q[CS][0] : rx_q[CS][0];
    sb = rn_q[CS][1] ? -ry_q[CS][1] : ry_q[CS][1];
    cb = rn_q[CS][1] ? -rx_q[CS][1] : rx_q[CS][1];
    cd = rn_q[CS][2] ? -rx_q[CS][2] : rx_q[CS][2];
  end

  always_ff @(posedge clk_i) begin
    logic signed [63:0] ssh, cch, th;
    logic signed [34:0] csum;
    if (en) begin
      ss_q  <= 64'(sa) * 64'(sb);
      cc_q  <= 64'(ca) * 64'(cb);
      cp_q  <= cd;
      ssh   = ss_q >>> 30;
      cch   = cc_q >>> 30;
      ss2_q <= ssh[33:0];
      cs_q  <= cch[31:0];
      cp2_q <= cp_q;
      t_q   <= 64'(cs_q) * 64'(cp2_q);
      ss3_q <= ss2_q;
      th    = t_q >>> 30;
      csum  = {ss3_q[33], ss3_q} + th[34:0];
      if (csum > 35'sd1073741824)       c_q <= 32'sd1073741824;
      else if (csum < -35'sd1073741824) c_q <= -32'sd1073741824;
      else                              c_q <= csum[31:0];
    end
  end

  // |c|, c^2, then 2^60 - c^2
  logic [30:0] ax1_q;
  logic        cn1_q;
  logic [61:0] sq_q;
  logic [61:0] sv_q [0:SQ];
  logic [61:0] sr_q [0:SQ];
  logic [30:0] cax_q [0:SQ];
  logic        cng_q [0:SQ];

  always_ff @(posedge clk_i) begin
    logic signed [31:0] axs;
    if (en) begin
      axs      = c_q[31] ? -c_q : c_q;
      ax1_q    <= axs[30:0];
      cn1_q    <= c_q[31];
      sq_q     <= 62'(axs[30:0]) * 62'(axs[30:0]);
      sv_q[0]  <= (62'd1 << 60) - sq_q;
      sr_q[0]  <= '0;
      cax_q[0] <= ax1_q;
      cng_q[0] <= cn1_q;
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 1; k <= SQ; k++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      logic [61:0] b, t;
      if (en) begin
        b = 62'd1 << (60 - 2*(k-1));
        t = sr_q[k-1] + b;
        if (sv_q[k-1] >= t) begin
          sv_q[k] <= sv_q[k-1] - t;
          sr_q[k] <= (sr_q[k-1] >> 1) + b;
        end else begin
          sv_q[k] <= sv_q[k-1];
          sr_q[k] <= sr_q[k-1] >> 1;
        end
        cax_q[k] <= cax_q[k-1];
        cng_q[k] <= cng_q[k-1];
      end
    end
  end

  // arctangent by vectoring: atan2(root, |c|)
  logic signed [31:0] vx_q [1:CS];
  logic signed [31:0] vy_q [1:CS];
  logic signed [31:0] vz_q [1:CS];
  logic               vn_q [1:CS];

  for (genvar i = 1; i <= CS; i++) begin : g_vec
    logic signed [31:0] px, py, pz, dx, dy;
    logic               pn;
    if (i == 1) begin : g_first
      assign px = {1'b0, cax_q[SQ]};
      assign py = sr_q[SQ][31:0];
      assign pz = '0;
      assign pn = cng_q[SQ];
    end else begin : g_next
      assign px = vx_q[i-1];
      assign py = vy_q[i-1];
      assign pz = vz_q[i-1];
      assign pn = vn_q[i-1];
    end
    assign dx = py >>> (i-1);
    assign dy = px >>> (i-1);
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (py > 32'sd0) begin
          vx_q[i] <= px + dx;
          vy_q[i] <= py - dy;
          vz_q[i] <= pz + gcd_pkg::atan_q30(i-1);
        end else begin
          vx_q[i] <= px - dx;
          vy_q[i] <= py + dy;
          vz_q[i] <= pz - gcd_pkg::atan_q30(i-1);
        end
        vn_q[i] <= pn;
      end
    end
  end

  // acos, scale by radius, round, saturate
  logic [31:0] ang_q;
  logic [55:0] prod_q;
  logic [gcd_pkg::OUT_W-1:0] dist_q;

  always_ff @(posedge clk_i) begin
    logic signed [33:0] zs, a;
    logic [56:0] ds;
    if (en) begin
      zs = {{2{vz_q[CS][31]}}, vz_q[CS]};
      a  = vn_q[CS] ? $signed({1'b0, gcd_pkg::PI_Q}) - zs : zs;
      ang_q  <= a[33] ? 32'd0 : a[31:0];
      prod_q <= 56'(ang_q) * 56'(radius_i);
      ds = {1'b0, prod_q} + (57'd1 << 29);
      if (ds[56:30] > 27'(gcd_pkg::OUT_MAX)) dist_q <= gcd_pkg::OUT_MAX;
      else                                   dist_q <= ds[30+gcd_pkg::OUT_W-1:30];
    end
  end

  assign out_valid_o      = vld_q[NSTG-1];
  assign arc_distance_m_o = dist_q;

  a_out_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> arc_distance_m_o <= gcd_pkg::OUT_MAX) else $error("distance above max");

endmodule
